@@ rtl/mfmi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmi_pkg: shared definitions for the folded modular inverse search
// Field widths, reset values, sequencer states and the divider status group.
// ----------------------------------------------------------------------------
package mfmi_pkg;

  localparam int ModulusW    = 32;  // width of the modulus field on the port
  localparam int MultW       = 8;   // width of a multiplier and of its register
  localparam int FoldW       = 31;  // width of the folded inverse field
  localparam int FirstMult   = 2;   // first multiplier tried
  localparam int MaxMultRst  = 20;  // reset value of the multiplier limit

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KCHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FOLD,
    ST_PICK,
    ST_NEXTK,
    ST_FINISH
  } mfmi_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mfmi_div_stat_t;

endpackage

@@ rtl/mfmi_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmi_if: valid/ready channels of the folded modular inverse search
// One channel carries the modulus in, the other carries the search result.
// ----------------------------------------------------------------------------
interface mfmi_in_if
  import mfmi_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ModulusW-1:0] modulus;

  modport source(output valid, output modulus, input ready);
  modport sink(input valid, input modulus, output ready);
endinterface

interface mfmi_out_if
  import mfmi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [MultW-1:0] best_multiplier;
  logic [FoldW-1:0] best_folded_inverse;

  modport source(output valid, output found, output best_multiplier,
                 output best_folded_inverse, input ready);
  modport sink(input valid, input found, input best_multiplier,
               input best_folded_inverse, output ready);
endinterface

@@ rtl/mfmi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmi_div: shared shift-subtract divider for the Euclid steps
// Restoring division, one quotient bit per cycle. Alongside the quotient it
// accumulates quotient times a signed coefficient, so the caller gets q*co
// without a multiplier.
// ----------------------------------------------------------------------------
module mfmi_div
  import mfmi_pkg::*;
#(
  parameter int WIDTH = ModulusW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [WIDTH-1:0]        dividend_i,
  input  logic [WIDTH-1:0]        divisor_i,
  input  logic signed [WIDTH+1:0] coef_i,
  output mfmi_div_stat_t          status_o,
  output logic [WIDTH-1:0]        rem_o,
  output logic signed [WIDTH+1:0] prod_o
);

  localparam int CoefW = WIDTH + 2;
  localparam int CntW  = $clog2(WIDTH);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [WIDTH-1:0]        part_q, part_d;
  logic [WIDTH-1:0]        num_q, num_d;
  logic [WIDTH-1:0]        dvs_q, dvs_d;
  logic signed [CoefW-1:0] coef_q, coef_d;
  logic signed [CoefW-1:0] acc_q, acc_d;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           take;
  logic           last;

  assign trial = {part_q, num_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};
  assign last  = cnt_q == CntW'(WIDTH - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    part_d = part_q;
    num_d  = num_q;
    dvs_d  = dvs_q;
    coef_d = coef_q;
    acc_d  = acc_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      part_d = '0;
      num_d  = dividend_i;
      dvs_d  = divisor_i;
      coef_d = coef_i;
      acc_d  = '0;
    end else if (busy_q) begin
      part_d = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      num_d  = {num_q[WIDTH-2:0], 1'b0};
      // Each quotient bit adds the coefficient into the running product.
      acc_d  = (acc_q <<< 1) + (take ? coef_q : '0);
      cnt_d  = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    num_q  <= num_d;
    dvs_q  <= dvs_d;
    coef_q <= coef_d;
    acc_q  <= acc_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = part_q;
  assign prod_o        = acc_q;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished division");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dvs_q != '0) |-> part_q < dvs_q)
    else $error("divider remainder not below the divisor");
`endif

endmodule

@@ rtl/min_folded_modular_inverse_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_folded_modular_inverse_search_top: smallest folded modular inverse
// For a modulus r, tries multipliers 2..max_multiplier, inverts each with
// the extended Euclidean algorithm and keeps the smallest min(inv, r-inv).
// ----------------------------------------------------------------------------
// One modulus is processed at a time; the input is ready again once the
// result has been placed in the output register, which may still be waiting
// to be taken. With a modulus below two, or a limit below two, the sequencer
// goes straight to its finish state, which places the result in the output
// register once that is free and returns to idle. Otherwise each multiplier
// passes through the sequencer states plus, for each Euclid step, one run of
// the shared shift-subtract divider (WIDTH = min(MODULUS_WIDTH, 32)); a
// multiplier below 256 needs at most about a dozen steps. The divider
// produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module min_folded_modular_inverse_search_top
  import mfmi_pkg::*;
#(
  parameter int MODULUS_WIDTH = ModulusW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MultW-1:0] cfg_wdata_i,
  mfmi_in_if.sink          in_i,
  mfmi_out_if.source       out_o
);

  localparam int RW = (MODULUS_WIDTH > ModulusW) ? ModulusW : MODULUS_WIDTH;
  localparam int CW = RW + 2;

  mfmi_state_e state_q, state_d;

  logic [MultW-1:0]     max_mult_q;
  logic [RW-1:0]        r_q;
  logic [MultW-1:0]     k_q;
  logic [RW-1:0]        a_q;
  logic [RW-1:0]        prev_rem_q, rem_q;
  logic signed [CW-1:0] prev_co_q, co_q;
  logic [RW-1:0]        inv_q;
  logic                 found_q;
  logic [MultW-1:0]     best_k_q;
  logic [RW-1:0]        best_t_q;

  logic                 out_valid_q;
  logic                 out_found_q;
  logic [MultW-1:0]     out_k_q;
  logic [FoldW-1:0]     out_t_q;

  logic                 in_ready;
  logic                 in_fire;
  logic                 out_free;
  logic                 div_start;
  mfmi_div_stat_t       div_stat;
  logic [RW-1:0]        div_rem;
  logic signed [CW-1:0] div_prod;

  logic [RW-1:0]        r_in;
  logic                 trivial;
  logic [RW-1:0]        a_inc;
  logic signed [CW-1:0] r_ext;
  logic signed [CW-1:0] inv_wide;
  logic [RW-1:0]        inv_neg;
  logic [RW-1:0]        t_val;
  logic                 better;
  logic [ModulusW-1:0]  t_ext;

  assign r_in     = in_i.modulus[RW-1:0];
  assign trivial  = (r_in < RW'(FirstMult)) || (max_mult_q < MultW'(FirstMult));
  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign a_inc    = a_q + RW'(1);
  assign r_ext    = $signed({2'b00, r_q});
  assign inv_wide = prev_co_q[CW-1] ? (prev_co_q + r_ext) : prev_co_q;
  assign inv_neg  = r_q - inv_q;
  assign t_val    = (inv_q < inv_neg) ? inv_q : inv_neg;
  assign better   = !found_q || (t_val < best_t_q);
  assign t_ext    = ModulusW'(best_t_q);

  mfmi_div #(
    .WIDTH(RW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prev_rem_q),
    .divisor_i (rem_q),
    .coef_i    (co_q),
    .status_o  (div_stat),
    .rem_o     (div_rem),
    .prod_o    (div_prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = trivial ? ST_FINISH : ST_KCHECK;
      end
      ST_KCHECK:    state_d = (a_q == '0) ? ST_NEXTK : ST_DIV_START;
      ST_DIV_START: state_d = (rem_q == '0) ? ST_FOLD : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) state_d = ST_DIV_START;
      end
      ST_FOLD:      state_d = (prev_rem_q == RW'(1)) ? ST_PICK : ST_NEXTK;
      ST_PICK:      state_d = ST_NEXTK;
      ST_NEXTK:     state_d = (k_q == max_mult_q) ? ST_FINISH : ST_KCHECK;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Handshake and divider control.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:      in_ready  = 1'b1;
      ST_DIV_START: div_start = (rem_q != '0);
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_mult_q  <= MultW'(MaxMultRst);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_mult_q <= cfg_wdata_i;
      if (in_fire) found_q <= 1'b0;
      else if (state_q == ST_PICK && better) found_q <= 1'b1;
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        r_q      <= r_in;
        k_q      <= MultW'(FirstMult);
        a_q      <= (r_in == RW'(FirstMult)) ? '0 : RW'(FirstMult);
        best_k_q <= '0;
        best_t_q <= '0;
      end
      ST_KCHECK: begin
        prev_rem_q <= r_q;
        rem_q      <= a_q;
        prev_co_q  <= '0;
        co_q       <= CW'(1);
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          prev_rem_q <= rem_q;
          rem_q      <= div_rem;
          prev_co_q  <= co_q;
          co_q       <= prev_co_q - div_prod;
        end
      end
      ST_FOLD:  inv_q <= inv_wide[RW-1:0];
      ST_PICK: begin
        if (better) begin
          best_k_q <= k_q;
          best_t_q <= t_val;
        end
      end
      ST_NEXTK: begin
        k_q <= k_q + MultW'(1);
        a_q <= (a_inc == r_q) ? '0 : a_inc;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_found_q <= found_q;
          out_k_q     <= best_k_q;
          out_t_q     <= t_ext[FoldW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready                = in_ready;
  assign out_o.valid               = out_valid_q;
  assign out_o.found               = out_found_q;
  assign out_o.best_multiplier     = out_k_q;
  assign out_o.best_folded_inverse = out_t_q;

`ifndef SYNTH
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |->
      (out_o.best_multiplier == '0 && out_o.best_folded_inverse == '0))
    else $error("result without an inverse carries nonzero fields");

  a_found_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> out_o.best_multiplier >= MultW'(FirstMult))
    else $error("reported multiplier below the first one tried");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |-> prev_rem_q != '0)
    else $error("Euclid finished with a zero gcd");

  a_div_idle_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_WAIT && !div_stat.done) |-> div_stat.busy)
    else $error("waiting on a divider that is not running");
`endif

endmodule
